>>> hw/rtl/ggbb_pkg.sv
// ggbb_pkg: shared types, constants and arithmetic helpers for the glow border blend.
// No dependencies; imported by every module of the block.

package ggbb_pkg;

    // frame size registers
    localparam int FRAME_W = 11;
    localparam int QW      = FRAME_W - 1;   // in-frame coordinate / distance width
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 11'd320;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 11'd240;
    localparam logic [FRAME_W-1:0] FRAME_MIN = 11'd8;
    localparam logic [FRAME_W-1:0] FRAME_MAX = 11'd1024;

    // pipeline layout
    localparam int RING_STG   = 0;
    localparam int DIV_FIRST  = 1;
    localparam int DIV_STAGES = 4;
    localparam int GRAD_STG   = DIV_FIRST + DIV_STAGES;
    localparam int MUL_STG    = GRAD_STG + 1;
    localparam int OUT_STG    = MUL_STG + 1;
    localparam int NSTAGES    = OUT_STG + 1;

    // gradient position: each quotient is 0..128
    localparam int QUO_W  = 8;
    localparam int POS_W  = QUO_W + 1;
    localparam int PROD_W = 18;

    localparam int MAX_ALPHA = 228;

    localparam logic [7:0] GRAD_A_R = 8'd150;
    localparam logic [7:0] GRAD_A_G = 8'd50;
    localparam logic [7:0] GRAD_A_B = 8'd255;
    localparam logic [7:0] GRAD_B_R = 8'd255;
    localparam logic [7:0] GRAD_B_G = 8'd40;
    localparam logic [7:0] GRAD_B_B = 8'd180;

    typedef struct packed {
        logic [NSTAGES-1:0] ld;    // stage register loads this cycle
        logic [NSTAGES-1:0] vld;   // stage holds a live request
    } pipe_ctl_t;

    typedef struct packed {
        logic [15:0] bg;
        logic        glow;
        logic [7:0]  alpha;
    } side_t;

    // clamped frame size minus one
    function automatic logic [QW-1:0] size_m1(input logic [FRAME_W-1:0] v);
        logic [FRAME_W-1:0] c;
        if (v < FRAME_MIN)
            c = FRAME_MIN;
        else if (v > FRAME_MAX)
            c = FRAME_MAX;
        else
            c = v;
        size_m1 = QW'(c - 11'd1);
    endfunction

    // a + (b - a) * t / 256, truncated toward zero
    function automatic logic [7:0] grad_ch(input logic [7:0] a, input logic [7:0] b,
                                           input logic [POS_W-1:0] t);
        logic [16:0] p;
        if (b >= a) begin
            p = 17'(b - a) * 17'(t);
            grad_ch = a + p[15:8];
        end
        else begin
            p = 17'(a - b) * 17'(t);
            grad_ch = a - p[15:8];
        end
    endfunction

    // (fg - bg) * alpha, signed
    function automatic logic signed [PROD_W-1:0] blend_mul(input logic [7:0] fg,
                                                           input logic [7:0] bgx,
                                                           input logic [7:0] alpha);
        logic signed [9:0]        d;
        logic signed [PROD_W-1:0] dw;
        logic signed [PROD_W-1:0] aw;
        d  = signed'({2'b00, fg}) - signed'({2'b00, bgx});
        dw = PROD_W'(d);
        aw = PROD_W'(signed'({1'b0, alpha}));
        blend_mul = dw * aw;
    endfunction

    // bg + prod / 255 toward zero; |prod| < 2^16 so the reciprocal trick is exact
    function automatic logic [7:0] blend_fin(input logic [7:0] bgx,
                                             input logic signed [PROD_W-1:0] prod);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sum;
        logic [7:0]        q;
        mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        sum = mag + (mag >> 8) + PROD_W'(1);
        q   = sum[15:8];
        blend_fin = prod[PROD_W-1] ? (bgx - q) : (bgx + q);
    endfunction

endpackage

>>> hw/rtl/ggbb_ctrl.sv
// ggbb_ctrl: valid bits and per-stage load enables of the pixel pipeline.
// Depends on ggbb_pkg. A stage loads when it is empty or the next one loads.

module ggbb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    output ggbb_pkg::pipe_ctl_t ctl
);
    import ggbb_pkg::*;

    logic [NSTAGES-1:0] vld_reg;
    logic [NSTAGES-1:0] vld_next;
    logic [NSTAGES-1:0] ld;

    always_comb
    begin
        ld[NSTAGES-1] = !vld_reg[NSTAGES-1] || out_ready;
        for (int k = NSTAGES - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ld[0])
            vld_next[0] = in_valid;
        for (int k = 1; k < NSTAGES; k++)
        begin
            if (ld[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign ctl.ld  = ld;
    assign ctl.vld = vld_reg;

    // a held stage keeps its request
    for (genvar k = 0; k < NSTAGES; k++)
    begin : g_hold_chk
        a_hold: assert property (@(posedge clk) disable iff (!rst_n)
            vld_reg[k] && !ld[k] |=> vld_reg[k])
            else $error("stage %0d dropped a held request", k);
    end

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && ld[0] |=> vld_reg[0])
        else $error("accepted request not captured");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !out_ready |-> !ld[0])
        else $error("full pipeline took a request while stalled");

endmodule

>>> hw/rtl/ggbb_ring.sv
// ggbb_ring: first stage; border distance, glow flag, alpha and divider operands.
// Depends on ggbb_pkg.

module ggbb_ring #(
    parameter int COORD_BITS = 10,
    parameter int GLOW_WIDTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ggbb_pkg::pipe_ctl_t       ctl,
    input  logic [COORD_BITS-1:0]     pixel_x,
    input  logic [COORD_BITS-1:0]     pixel_y,
    input  logic [15:0]               background_pixel,
    input  logic [ggbb_pkg::QW-1:0]   wm1,
    input  logic [ggbb_pkg::QW-1:0]   hm1,
    output ggbb_pkg::side_t           side,
    output logic [ggbb_pkg::QW-1:0]   dx,
    output logic [ggbb_pkg::QW-1:0]   yq
);
    import ggbb_pkg::*;

    localparam int CMP_W = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;
    localparam int DW    = $clog2(GLOW_WIDTH + 1);

    logic [7:0] alpha_tab [2**DW];

    for (genvar i = 0; i < 2**DW; i++)
    begin : g_alpha
        assign alpha_tab[i] = (i < GLOW_WIDTH) ?
                              8'((MAX_ALPHA * (GLOW_WIDTH - i)) / GLOW_WIDTH) : 8'd0;
    end

    logic [CMP_W-1:0] x_ext;
    logic [CMP_W-1:0] y_ext;
    logic [QW-1:0]    x_q;
    logic [QW-1:0]    y_q;
    logic [QW-1:0]    dx_c;
    logic [QW-1:0]    dy_c;
    logic [QW-1:0]    m1;
    logic [QW-1:0]    m2;
    logic [QW-1:0]    ring_dist;
    logic             in_frame;
    side_t            side_next;
    side_t            side_reg;
    logic [QW-1:0]    dx_reg;
    logic [QW-1:0]    yq_reg;

    assign x_ext     = CMP_W'(pixel_x);
    assign y_ext     = CMP_W'(pixel_y);
    assign x_q       = x_ext[QW-1:0];
    assign y_q       = y_ext[QW-1:0];
    assign in_frame  = (x_ext <= CMP_W'(wm1)) && (y_ext <= CMP_W'(hm1));
    assign dx_c      = wm1 - x_q;
    assign dy_c      = hm1 - y_q;
    assign m1        = (x_q < y_q) ? x_q : y_q;
    assign m2        = (dx_c < dy_c) ? dx_c : dy_c;
    assign ring_dist = (m1 < m2) ? m1 : m2;

    always_comb
    begin
        side_next.bg    = background_pixel;
        side_next.glow  = in_frame && (ring_dist < QW'(GLOW_WIDTH));
        side_next.alpha = alpha_tab[ring_dist[DW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[RING_STG])
        begin
            side_reg <= side_next;
            dx_reg   <= dx_c;
            yq_reg   <= y_q;
        end
    end

    assign side = side_reg;
    assign dx   = dx_reg;
    assign yq   = yq_reg;

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.vld[RING_STG] && side_reg.glow |-> side_reg.alpha != 8'd0)
        else $error("glow pixel with zero alpha");

endmodule

>>> hw/rtl/ggbb_div.sv
// ggbb_div: pipelined restoring divider, floor(a * 128 / d) for a <= d.
// Depends on ggbb_pkg. Two compare-subtract steps per stage.

module ggbb_div (
    input  logic                       clk,
    input  ggbb_pkg::pipe_ctl_t        ctl,
    input  logic [ggbb_pkg::QW-1:0]    dividend,
    input  logic [ggbb_pkg::QW-1:0]    divisor,
    output logic [ggbb_pkg::QUO_W-1:0] quotient
);
    import ggbb_pkg::*;

    localparam int STEPS = QUO_W / DIV_STAGES;

    logic [QW-1:0]    rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [QW-1:0]    rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [QW-1:0]    rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin : p_step
            logic [QW:0]   tr;
            logic [QW-1:0] r;
            logic [QUO_W-1:0] q;
            r = rem_in;
            q = quo_in;
            for (int j = 0; j < STEPS; j++)
            begin
                // first step weighs 128 and takes the remainder as is
                tr = (k * STEPS + j == 0) ? {1'b0, r} : {r, 1'b0};
                if (tr >= {1'b0, divisor})
                begin
                    r = QW'(tr - {1'b0, divisor});
                    q[QUO_W-1-(k*STEPS+j)] = 1'b1;
                end
                else
                begin
                    r = tr[QW-1:0];
                end
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.ld[DIV_FIRST+k])
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

>>> hw/rtl/ggbb_blend.sv
// ggbb_blend: gradient color, alpha blend products, divide by 255 and RGB565 pack.
// Depends on ggbb_pkg. Three register stages.

module ggbb_blend (
    input  logic                       clk,
    input  ggbb_pkg::pipe_ctl_t        ctl,
    input  logic [ggbb_pkg::QUO_W-1:0] qx,
    input  logic [ggbb_pkg::QUO_W-1:0] qy,
    input  ggbb_pkg::side_t            side,
    output logic [15:0]                pixel_out,
    output logic                       in_glow
);
    import ggbb_pkg::*;

    logic [POS_W-1:0] t;
    logic [7:0]       gr_reg;
    logic [7:0]       gg_reg;
    logic [7:0]       gb_reg;
    side_t            grad_side_reg;

    logic signed [PROD_W-1:0] pr_reg;
    logic signed [PROD_W-1:0] pg_reg;
    logic signed [PROD_W-1:0] pb_reg;
    logic [15:0]              mul_bg_reg;
    logic                     mul_glow_reg;

    logic [7:0]  bxr;
    logic [7:0]  bxg;
    logic [7:0]  bxb;
    logic [7:0]  or_c;
    logic [7:0]  og_c;
    logic [7:0]  ob_c;
    logic [15:0] pix_next;
    logic [15:0] pix_reg;
    logic        glow_reg;

    assign t = POS_W'(qx) + POS_W'(qy);

    always_ff @(posedge clk)
    begin
        if (ctl.ld[GRAD_STG])
        begin
            gr_reg        <= grad_ch(GRAD_A_R, GRAD_B_R, t);
            gg_reg        <= grad_ch(GRAD_A_G, GRAD_B_G, t);
            gb_reg        <= grad_ch(GRAD_A_B, GRAD_B_B, t);
            grad_side_reg <= side;
        end
    end

    // expanded background, no bit replication
    always_comb
    begin
        bxr = {grad_side_reg.bg[15:11], 3'b000};
        bxg = {grad_side_reg.bg[10:5], 2'b00};
        bxb = {grad_side_reg.bg[4:0], 3'b000};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[MUL_STG])
        begin
            pr_reg       <= blend_mul(gr_reg, bxr, grad_side_reg.alpha);
            pg_reg       <= blend_mul(gg_reg, bxg, grad_side_reg.alpha);
            pb_reg       <= blend_mul(gb_reg, bxb, grad_side_reg.alpha);
            mul_bg_reg   <= grad_side_reg.bg;
            mul_glow_reg <= grad_side_reg.glow;
        end
    end

    always_comb
    begin
        or_c = blend_fin({mul_bg_reg[15:11], 3'b000}, pr_reg);
        og_c = blend_fin({mul_bg_reg[10:5], 2'b00}, pg_reg);
        ob_c = blend_fin({mul_bg_reg[4:0], 3'b000}, pb_reg);
        if (mul_glow_reg)
            pix_next = {or_c[7:3], og_c[7:2], ob_c[7:3]};
        else
            pix_next = mul_bg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[OUT_STG])
        begin
            pix_reg  <= pix_next;
            glow_reg <= mul_glow_reg;
        end
    end

    assign pixel_out = pix_reg;
    assign in_glow   = glow_reg;

endmodule

>>> hw/rtl/gradient_glow_border_blend.sv
// Gradient glow border blend: RGB565 pixels near the frame edge get a blended gradient.
// Pipeline of 8 stages; each border divider is 4 stages of 2 subtract steps.
// Throughput: one pixel per cycle while the output is not stalled.
// Stalls ripple back stage by stage; empty stages keep taking requests.
// Reset clears all stage valid bits and sets frame size to 320 x 240.
// Depends on ggbb_pkg, ggbb_ctrl, ggbb_ring, ggbb_div, ggbb_blend.

module gradient_glow_border_blend #(
    parameter int COORD_BITS = 10,
    parameter int GLOW_WIDTH = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ggbb_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [ggbb_pkg::FRAME_W-1:0]          cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pixel_x, pixel_y, background_pixel, zero fill
    input  logic [((2*COORD_BITS+23)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_out
    output logic [15:0]                           m_tdata,
    // in_glow
    output logic                                  m_tuser
);
    import ggbb_pkg::*;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;
    logic [QW-1:0]      wm1;
    logic [QW-1:0]      hm1;

    pipe_ctl_t        ctl;
    side_t            ring_side;
    logic [QW-1:0]    ring_dx;
    logic [QW-1:0]    ring_yq;
    side_t            side_reg [DIV_STAGES];
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign wm1 = size_m1(frame_width_reg);
    assign hm1 = size_m1(frame_height_reg);

    ggbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    ggbb_ring #(
        .COORD_BITS (COORD_BITS),
        .GLOW_WIDTH (GLOW_WIDTH)
    ) u_ring (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .pixel_x          (s_tdata[COORD_BITS-1:0]),
        .pixel_y          (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .background_pixel (s_tdata[2*COORD_BITS+15:2*COORD_BITS]),
        .wm1              (wm1),
        .hm1              (hm1),
        .side             (ring_side),
        .dx               (ring_dx),
        .yq               (ring_yq)
    );

    // (W-1-x)*128/(W-1)
    ggbb_div u_div_x (
        .clk      (clk),
        .ctl      (ctl),
        .dividend (ring_dx),
        .divisor  (wm1),
        .quotient (qx)
    );

    // y*128/(H-1)
    ggbb_div u_div_y (
        .clk      (clk),
        .ctl      (ctl),
        .dividend (ring_yq),
        .divisor  (hm1),
        .quotient (qy)
    );

    // side payload rides alongside the divider stages
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (ctl.ld[DIV_FIRST+k])
                side_reg[k] <= (k == 0) ? ring_side : side_reg[(k == 0) ? 0 : k-1];
        end
    end

    ggbb_blend u_blend (
        .clk       (clk),
        .ctl       (ctl),
        .qx        (qx),
        .qy        (qy),
        .side      (side_reg[DIV_STAGES-1]),
        .pixel_out (m_tdata),
        .in_glow   (m_tuser)
    );

    assign s_tready = ctl.ld[RING_STG];
    assign m_tvalid = ctl.vld[OUT_STG];

    a_quo: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.vld[GRAD_STG-1] && side_reg[DIV_STAGES-1].glow
            |-> (qx <= QUO_W'(128)) && (qy <= QUO_W'(128)))
        else $error("gradient quotient out of range");

endmodule
